/* rtl/speech_activity_detector_defines.svh */
// assertion macros used by the detector top-level rtl file
`ifndef SPEECH_ACTIVITY_DETECTOR_DEFINES_SVH
`define SPEECH_ACTIVITY_DETECTOR_DEFINES_SVH

// same-cycle implication, checked on clk, muted during reset
`define SAD_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// next-cycle implication, checked on clk, muted during reset
`define SAD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

/* rtl/sad_pkg.sv */
`timescale 1ns / 1ps
package sad_pkg;

    localparam int unsigned SAMPLE_W = 16;
    localparam int unsigned LEVEL_W  = 15;
    localparam int unsigned MULT_W   = 4;
    localparam int unsigned COUNT_W  = 8;
    localparam int unsigned PROD_W   = LEVEL_W + MULT_W;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 15;

    localparam logic [MULT_W-1:0]  MULT_RESET      = 4'd3;
    localparam logic [LEVEL_W-1:0] FLOOR_RESET     = 15'd120;
    localparam logic [LEVEL_W-1:0] CEILING_RESET   = 15'd2500;
    localparam logic [LEVEL_W-1:0] NOISE_MIN_RESET = 15'd8;
    localparam logic [COUNT_W-1:0] HANG_RESET      = 8'd35;
    localparam logic [LEVEL_W-1:0] NOISE_RESET     = 15'd40;
    localparam logic [LEVEL_W-1:0] PEAK_MAX        = 15'h7fff;
    localparam logic [COUNT_W-1:0] COUNT_MAX       = 8'hff;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MULTIPLIER = 3'd0,
        REG_FLOOR      = 3'd1,
        REG_CEILING    = 3'd2,
        REG_NOISE_MIN  = 3'd3,
        REG_HANG       = 3'd4
    } sad_reg_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       chunk_end;
        logic                       muted;
    } sad_in_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] chunk_peak;
        logic [LEVEL_W-1:0] noise_level;
        logic [LEVEL_W-1:0] threshold;
        logic               hearing;
    } sad_out_t;

    typedef struct packed {
        logic [MULT_W-1:0]  threshold_multiplier;
        logic [LEVEL_W-1:0] threshold_floor;
        logic [LEVEL_W-1:0] threshold_ceiling;
        logic [LEVEL_W-1:0] noise_minimum;
        logic [COUNT_W-1:0] hang_chunks;
    } sad_cfg_t;

    typedef struct packed {
        logic fire;
        logic chunk_end;
        logic muted;
    } sad_step_t;

endpackage

/* rtl/speech_activity_detector.sv */
`timescale 1ns / 1ps
// speech activity detector with an adaptive noise floor
// input channel: in_valid / in_stall carry one pcm sample per request, with a
// chunk-end mark and the mute flag. output channel: out_valid / out_stall carry
// one result per chunk (peak, noise floor, threshold, hearing).
// configuration: cfg_we writes cfg_data into register cfg_index;
// write only while no request is in flight.
// path: a request is registered in the input register on acceptance; a
// chunk end's result is registered in the result register as it advances.
// throughput: one request per cycle unless a chunk end waits on a held result;
// the threshold and noise update between the two registers is combinational.
// stall: a pending result is held; samples that are not chunk ends keep
// flowing, and a chunk-end request waits in the input register until the
// result register is free, which then stalls the input.
// reset: clears the running peak, hearing and hang count, noise floor to 40,
// configuration registers to their defaults.
`include "speech_activity_detector_defines.svh"
module speech_activity_detector
    import sad_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  sad_in_t               in_data,
    output logic                  out_valid,
    input  logic                  out_stall,
    output sad_out_t              out_data,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    sad_cfg_t           cfg_reg;
    logic               in_valid_reg;
    sad_in_t            in_data_reg;
    logic               out_valid_reg;
    sad_out_t           out_data_reg;
    logic               advance;
    logic               accept;
    sad_step_t          step;
    logic [LEVEL_W-1:0] chunk_peak;
    sad_out_t           result;

    assign advance = in_valid_reg &&
                     (!in_data_reg.chunk_end || !out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !advance;
    assign accept   = in_valid && !in_stall;

    assign step.fire      = advance;
    assign step.chunk_end = in_data_reg.chunk_end;
    assign step.muted     = in_data_reg.muted;

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    sad_peak_tracker u_peak
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .sample     (in_data_reg.sample),
        .chunk_peak (chunk_peak)
    );

    sad_decision u_decision
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .cfg        (cfg_reg),
        .chunk_peak (chunk_peak),
        .result     (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.threshold_multiplier <= MULT_RESET;
            cfg_reg.threshold_floor      <= FLOOR_RESET;
            cfg_reg.threshold_ceiling    <= CEILING_RESET;
            cfg_reg.noise_minimum        <= NOISE_MIN_RESET;
            cfg_reg.hang_chunks          <= HANG_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_MULTIPLIER: cfg_reg.threshold_multiplier <= cfg_data[MULT_W-1:0];
                REG_FLOOR:      cfg_reg.threshold_floor      <= cfg_data[LEVEL_W-1:0];
                REG_CEILING:    cfg_reg.threshold_ceiling    <= cfg_data[LEVEL_W-1:0];
                REG_NOISE_MIN:  cfg_reg.noise_minimum        <= cfg_data[LEVEL_W-1:0];
                REG_HANG:       cfg_reg.hang_chunks          <= cfg_data[COUNT_W-1:0];
                default:        ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end
            if (advance && in_data_reg.chunk_end)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_data_reg <= in_data;
        end
        if (advance && in_data_reg.chunk_end)
        begin
            out_data_reg <= result;
        end
    end

    // a chunk end always yields a result next cycle
    `SAD_ASSERT_NEXT(a_chunk_gives_result, advance && in_data_reg.chunk_end, out_valid_reg)
    // a held result is never overwritten
    `SAD_ASSERT_NOW(a_no_overwrite, out_valid_reg && out_stall,
                    !(advance && in_data_reg.chunk_end))
    // a request that cannot move keeps its slot
    `SAD_ASSERT_NEXT(a_input_holds, in_valid_reg && !advance,
                     in_valid_reg && $stable(in_data_reg))
    // a muted chunk never reports hearing
    `SAD_ASSERT_NOW(a_muted_silent, advance && in_data_reg.chunk_end && in_data_reg.muted,
                    !result.hearing && (result.chunk_peak == '0))

endmodule

/* rtl/sad_peak_tracker.sv */
`timescale 1ns / 1ps
module sad_peak_tracker
    import sad_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  sad_step_t                  step,
    input  logic signed [SAMPLE_W-1:0] sample,
    output logic [LEVEL_W-1:0]         chunk_peak
);

    logic [LEVEL_W-1:0]  running_peak_reg;
    logic [LEVEL_W-1:0]  running_peak_next;
    logic [SAMPLE_W-1:0] neg_sample;
    logic [LEVEL_W-1:0]  mag;

    // absolute value, full-scale negative saturates
    always_comb
    begin
        neg_sample = SAMPLE_W'(0) - SAMPLE_W'(sample);
        if (sample[SAMPLE_W-1])
        begin
            mag = neg_sample[SAMPLE_W-1] ? PEAK_MAX : neg_sample[LEVEL_W-1:0];
        end
        else
        begin
            mag = sample[LEVEL_W-1:0];
        end
    end

    always_comb
    begin
        if (!step.muted && (mag > running_peak_reg))
        begin
            chunk_peak = mag;
        end
        else
        begin
            chunk_peak = running_peak_reg;
        end
        running_peak_next = running_peak_reg;
        if (step.fire)
        begin
            running_peak_next = step.chunk_end ? '0 : chunk_peak;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_peak_reg <= '0;
        end
        else
        begin
            running_peak_reg <= running_peak_next;
        end
    end

endmodule

/* rtl/sad_decision.sv */
`timescale 1ns / 1ps
module sad_decision
    import sad_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  sad_step_t          step,
    input  sad_cfg_t           cfg,
    input  logic [LEVEL_W-1:0] chunk_peak,
    output sad_out_t           result
);

    logic [LEVEL_W-1:0] noise_floor_reg;
    logic [LEVEL_W-1:0] noise_floor_next;
    logic               hearing_reg;
    logic               hearing_next;
    logic               heard_ever_reg;
    logic               heard_ever_next;
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;

    logic [PROD_W-1:0]  product;
    logic [PROD_W-1:0]  floored;
    logic [PROD_W-1:0]  clamped;
    logic [LEVEL_W-1:0] thresh;
    logic [PROD_W-1:0]  blend;
    logic [LEVEL_W-1:0] relaxed;
    logic [COUNT_W-1:0] count_adv;
    logic               loud;

    always_comb
    begin
        product = PROD_W'(noise_floor_reg) * PROD_W'(cfg.threshold_multiplier);
        floored = (product < PROD_W'(cfg.threshold_floor)) ?
                  PROD_W'(cfg.threshold_floor) : product;
        clamped = (floored > PROD_W'(cfg.threshold_ceiling)) ?
                  PROD_W'(cfg.threshold_ceiling) : floored;
        thresh  = clamped[LEVEL_W-1:0];
    end

    // noise relaxes as (15 * noise + peak) / 16, held at the minimum
    always_comb
    begin
        blend   = (PROD_W'(noise_floor_reg) << 4) - PROD_W'(noise_floor_reg)
                  + PROD_W'(chunk_peak);
        relaxed = blend[PROD_W-1:4];
        if (relaxed < cfg.noise_minimum)
        begin
            relaxed = cfg.noise_minimum;
        end
        count_adv = (count_reg == COUNT_MAX) ? count_reg : count_reg + COUNT_W'(1);
        loud      = (chunk_peak >= thresh);
    end

    always_comb
    begin
        noise_floor_next = noise_floor_reg;
        hearing_next     = hearing_reg;
        heard_ever_next  = heard_ever_reg;
        count_next       = count_reg;
        if (step.muted)
        begin
            hearing_next = 1'b0;
            count_next   = count_adv;
        end
        else
        begin
            if (loud)
            begin
                hearing_next    = 1'b1;
                heard_ever_next = 1'b1;
                count_next      = '0;
            end
            else
            begin
                if (!hearing_reg)
                begin
                    noise_floor_next = relaxed;
                end
                count_next = count_adv;
            end
            if (!heard_ever_next || (count_next > cfg.hang_chunks))
            begin
                hearing_next = 1'b0;
            end
        end
        result.chunk_peak  = step.muted ? '0 : chunk_peak;
        result.noise_level = noise_floor_reg;
        result.threshold   = thresh;
        result.hearing     = hearing_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            noise_floor_reg <= NOISE_RESET;
            hearing_reg     <= 1'b0;
            heard_ever_reg  <= 1'b0;
            count_reg       <= '0;
        end
        else if (step.fire && step.chunk_end)
        begin
            noise_floor_reg <= noise_floor_next;
            hearing_reg     <= hearing_next;
            heard_ever_reg  <= heard_ever_next;
            count_reg       <= count_next;
        end
    end

endmodule
